@@ src/mrc_pkg.sv @@
`default_nettype none
package mrc_pkg;

	// largest register count of one reply
	localparam logic [6:0] MRC_MAX_WORDS = 7'd125;

	localparam logic [7:0]  FN_READ  = 8'h04;
	localparam logic [7:0]  FN_WRITE = 8'h10;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// header lengths in bytes
	localparam logic [7:0] RD_HDR_LEN = 8'd3;
	localparam logic [7:0] WR_HDR_LEN = 8'd6;

	typedef enum logic [1:0] {
		CFG_SLAVE_ADDR = 2'd0,
		CFG_WRITE_MODE = 2'd1,
		CFG_REG_ADDR   = 2'd2,
		CFG_WORD_COUNT = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_HDR_FAIL = 2'd1,
		ST_CRC_FAIL = 2'd2
	} frame_status_t;

	typedef enum logic {
		KIND_DATA   = 1'b0,
		KIND_STATUS = 1'b1
	} result_kind_t;

	typedef enum logic {
		REQ_BYTE  = 1'b0,
		REQ_START = 1'b1
	} req_type_t;

	// reflected CRC-16, one byte, unrolled over its eight bits
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ src/mrc_in_if.sv @@
`default_nettype none
interface mrc_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] rx_byte;

	modport source (output valid, output req_type, output rx_byte, input ready);
	modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ src/mrc_out_if.sv @@
`default_nettype none
interface mrc_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [15:0] data_word;
	logic [6:0]  word_index;
	logic [1:0]  frame_status;
	logic        frame_last;

	modport source (
		output valid, output result_kind, output data_word, output word_index,
		output frame_status, output frame_last, input ready
	);
	modport sink (
		input valid, input result_kind, input data_word, input word_index,
		input frame_status, input frame_last, output ready
	);
endinterface
`default_nettype wire

@@ src/modbus_rtu_response_checker.sv @@
// Modbus RTU reply checker. Feed the reply one byte per beat on req (req_type 0),
// preceded by a start beat (req_type 1) that clears the frame state; bytes sent
// before any start beat after reset also form a frame. With write_mode 0 the block
// expects a read-input-registers reply (function 0x04): it checks slave address,
// function and byte count, emits each big-endian data word on rsp as its low byte
// arrives, then ends with a status beat from the CRC-16 check (poly 0xA001, init
// 0xFFFF, CRC low byte first). With write_mode 1 it compares the six echoed header
// bytes of a write-multiple-registers reply (0x10) and the CRC. A header mismatch
// ends the frame at the first wrong byte with status 1; a CRC mismatch gives 2.
// Data words precede the verdict, so drop them unless the final status is ok.
// Bytes after the status beat are ignored until the next start beat. word_count
// above 125 is taken as 125. Rate: one beat per cycle sustained while no blocked result
// stalls the input; a beat waits in the input register and its result then sits in
// the output register, which drives rsp.valid. A result held by a stalled sink
// blocks the input only when the next byte also has a result. The longest path is
// the single-byte unrolled CRC update from the input register to crc_q. Write
// configuration only while the block is idle.
`default_nettype none
module modbus_rtu_response_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	mrc_in_if.sink           req,
	mrc_out_if.source        rsp
);
	import mrc_pkg::*;

	// configuration registers
	logic [7:0]  slave_addr_q;
	logic        write_mode_q;
	logic [15:0] reg_addr_q;
	logic [6:0]  word_count_q;

	// input stage
	logic        valid_s1;
	logic        req_type_s1;
	logic [7:0]  rx_byte_s1;

	// frame state
	logic [7:0]  byte_pos_q;
	logic [15:0] crc_q;
	logic [7:0]  held_hi_q;
	logic [7:0]  crc_lo_q;
	logic        done_q;

	// output register
	logic        out_valid_q;
	logic        out_kind_q;
	logic [15:0] out_word_q;
	logic [6:0]  out_index_q;
	logic [1:0]  out_status_q;

	logic [6:0]  wc;
	logic [7:0]  data_end;
	logic        is_hdr;
	logic [7:0]  expect_byte;
	logic        hdr_bad;
	logic        is_data;
	logic        is_crc_lo;
	logic [15:0] crc_next;
	logic [7:0]  pos_m4;
	logic        byte_live;
	logic        has_result;
	logic        res_kind;
	logic [1:0]  res_status;
	logic        s1_adv;
	logic        in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= 8'd1;
			write_mode_q <= 1'b0;
			reg_addr_q   <= 16'd0;
			word_count_q <= 7'd1;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_SLAVE_ADDR: slave_addr_q <= cfg_data[7:0];
				CFG_WRITE_MODE: write_mode_q <= cfg_data[0];
				CFG_REG_ADDR:   reg_addr_q   <= cfg_data;
				CFG_WORD_COUNT: word_count_q <= cfg_data[6:0];
				default:        slave_addr_q <= slave_addr_q;
			endcase
		end
	end

	// ---- decode of the byte in the input stage ----
	always_comb begin
		wc = (word_count_q > MRC_MAX_WORDS) ? MRC_MAX_WORDS : word_count_q;
		expect_byte = 8'h00;
		if (write_mode_q) begin
			data_end = WR_HDR_LEN;
			is_hdr   = byte_pos_q < WR_HDR_LEN;
			case (byte_pos_q[2:0])
				3'd0:    expect_byte = slave_addr_q;
				3'd1:    expect_byte = FN_WRITE;
				3'd2:    expect_byte = reg_addr_q[15:8];
				3'd3:    expect_byte = reg_addr_q[7:0];
				3'd4:    expect_byte = 8'h00;   // count high byte, always zero
				default: expect_byte = {1'b0, wc};
			endcase
		end else begin
			data_end = RD_HDR_LEN + {wc, 1'b0};
			is_hdr   = byte_pos_q < RD_HDR_LEN;
			case (byte_pos_q[1:0])
				2'd0:    expect_byte = slave_addr_q;
				2'd1:    expect_byte = FN_READ;
				default: expect_byte = {wc, 1'b0};
			endcase
		end
		hdr_bad   = is_hdr && (rx_byte_s1 != expect_byte);
		is_data   = !is_hdr && (byte_pos_q < data_end);
		is_crc_lo = !is_hdr && (byte_pos_q == data_end);
		crc_next  = crc16_byte(crc_q, rx_byte_s1);
		pos_m4    = byte_pos_q - 8'd4;
	end

	assign byte_live = valid_s1 && (req_type_s1 == REQ_BYTE) && !done_q;

	always_comb begin
		has_result = 1'b0;
		res_kind   = KIND_DATA;
		res_status = ST_OK;
		if (byte_live) begin
			if (hdr_bad) begin
				has_result = 1'b1;
				res_kind   = KIND_STATUS;
				res_status = ST_HDR_FAIL;
			end else if (is_data) begin
				// word completes on its low byte (even position past the header)
				has_result = !byte_pos_q[0];
			end else if (!is_hdr && !is_crc_lo) begin
				has_result = 1'b1;
				res_kind   = KIND_STATUS;
				res_status = ({rx_byte_s1, crc_lo_q} == crc_q) ? ST_OK : ST_CRC_FAIL;
			end
		end
	end

	// input stage moves on unless its result is blocked by a full output register
	assign s1_adv    = valid_s1 && (!has_result || !out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || s1_adv;
	assign in_fire   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_type_s1 <= req.req_type;
			rx_byte_s1  <= req.rx_byte;
		end
	end

	// ---- frame state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= 8'd0;
			crc_q      <= CRC_INIT;
			held_hi_q  <= 8'd0;
			crc_lo_q   <= 8'd0;
			done_q     <= 1'b0;
		end else if (s1_adv) begin
			if (req_type_s1 == REQ_START) begin
				byte_pos_q <= 8'd0;
				crc_q      <= CRC_INIT;
				held_hi_q  <= 8'd0;
				crc_lo_q   <= 8'd0;
				done_q     <= 1'b0;
			end else if (!done_q) begin
				byte_pos_q <= byte_pos_q + 8'd1;
				if (has_result && (res_kind == KIND_STATUS)) begin
					done_q <= 1'b1;
				end
				if ((is_hdr && !hdr_bad) || is_data) begin
					crc_q <= crc_next;
				end
				if (is_data && byte_pos_q[0]) begin
					held_hi_q <= rx_byte_s1;
				end
				if (is_crc_lo) begin
					crc_lo_q <= rx_byte_s1;
				end
			end
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && has_result) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && has_result) begin
			out_kind_q   <= res_kind;
			out_status_q <= res_status;
			if (res_kind == KIND_DATA) begin
				out_word_q  <= {held_hi_q, rx_byte_s1};
				out_index_q <= pos_m4[7:1];
			end else begin
				out_word_q  <= 16'd0;
				out_index_q <= 7'd0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_kind  = out_kind_q;
	assign rsp.data_word    = out_word_q;
	assign rsp.word_index   = out_index_q;
	assign rsp.frame_status = out_status_q;
	assign rsp.frame_last   = out_kind_q;

	// ---- checks ----
	// a status result ends the frame
	a_status_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && has_result && (res_kind == KIND_STATUS)) |=> done_q)
		else $error("status result did not close the frame");

	// a closed frame produces nothing more
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !has_result)
		else $error("result produced after frame end");

	// an open frame never runs past the CRC bytes of the longest reply
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!done_q |-> (byte_pos_q <= 8'd254))
		else $error("byte position overran the frame");

	// a blocked result holds the input stage
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && has_result && out_valid_q && !rsp.ready) |-> !req.ready)
		else $error("input taken while its result was blocked");

endmodule
`default_nettype wire
